// ===== rtl/pso_pkg.sv =====
// ----------------------------------------------------------------------------
// pso_pkg: shared types and constants of the particle update block
// Action codes, configuration register indexes, reset values and fixed widths.
// ----------------------------------------------------------------------------
package pso_pkg;

  // Width of the coefficient registers and of the configuration data.
  localparam int CoefWidth    = 32;
  localparam int CfgIdxWidth  = 3;
  localparam int DimCntWidth  = 7;
  localparam int GenWidth     = 16;
  localparam int IndexWidth   = 6;
  localparam int RandWidth    = 17;
  localparam int FracBits     = 16;

  localparam logic [RandWidth-1:0] RandOne      = RandWidth'(65536);
  localparam logic [CoefWidth-1:0] ResetInertia = CoefWidth'(65536);
  localparam logic [CoefWidth-1:0] ResetAccel   = CoefWidth'(97940);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_SETFIT = 2'd3
  } action_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_INERTIA  = 3'd0,
    CFG_PERSONAL = 3'd1,
    CFG_SOCIAL   = 3'd2,
    CFG_DIMCOUNT = 3'd3,
    CFG_GENLIMIT = 3'd4
  } cfg_index_e;

endpackage

// ===== rtl/pso_limit_clamp.sv =====
// ----------------------------------------------------------------------------
// pso_limit_clamp: saturation and limit clamp
// Saturates a wide signed value to the value range, then applies max and min
// limits unless both limits are zero.
// ----------------------------------------------------------------------------
module pso_limit_clamp #(
  parameter int W  = 32,
  parameter int IW = 33
) (
  input  logic signed [IW-1:0] value_i,
  input  logic signed [W-1:0]  lo_i,
  input  logic signed [W-1:0]  hi_i,
  output logic signed [W-1:0]  value_o
);

  localparam logic signed [IW-1:0] SatHi = IW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [IW-1:0] SatLo = ~SatHi;

  logic signed [W-1:0] sat;
  logic signed [W-1:0] capped;

  always_comb begin
    if (value_i > SatHi) begin
      sat = SatHi[W-1:0];
    end else if (value_i < SatLo) begin
      sat = SatLo[W-1:0];
    end else begin
      sat = value_i[W-1:0];
    end
    // The lower limit wins when the limits are inverted.
    capped = (sat > hi_i) ? hi_i : sat;
    if (capped < lo_i) begin
      capped = lo_i;
    end
    value_o = (lo_i == '0 && hi_i == '0) ? sat : capped;
  end

endmodule

// ===== rtl/pso_particle_update.sv =====
// ----------------------------------------------------------------------------
// pso_particle_update: one particle of a fixed-point swarm optimiser
// Per-dimension state in two synchronous memories, each with one read and
// one write port, updated by read-modify-write under a small sequencer.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (valid/stall) and each produces
// exactly one result transaction on the output channel. Configuration
// registers are written over a separate valid/ready port, which is always
// ready; write them only while the block is idle.
// Sequencing: a load, set-fitness or report without improvement goes
// straight to the emit state; a dimension update for an index in use first
// passes through the read, multiply, velocity and position states, set by
// the two chained multiplier stages, the adder and the two clamps; an
// improving report first runs the personal best copy, which reads and then
// writes one memory row per entry, in separate read and write states, for
// each of the N dimensions in use.
// The input is stalled while an item is being worked on. The result sits in
// an output register, so the next item is accepted while a result waits;
// when the receiver stalls, the following result is held back until the
// register frees up. Reset clears the sequencer, the output valid, the
// generation count, the personal best fitness and the configuration; memory
// contents are undefined until loaded, so no clearing pass is run.
// ----------------------------------------------------------------------------
module pso_particle_update
  import pso_pkg::*;
#(
  parameter int MAX_DIMENSIONS = 64,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [CoefWidth-1:0]          cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [IndexWidth-1:0]         index_i,
  input  logic signed [VALUE_WIDTH-1:0] primary_value_i,
  input  logic signed [VALUE_WIDTH-1:0] secondary_value_i,
  input  logic signed [VALUE_WIDTH-1:0] min_position_i,
  input  logic signed [VALUE_WIDTH-1:0] max_position_i,
  input  logic signed [VALUE_WIDTH-1:0] min_velocity_i,
  input  logic signed [VALUE_WIDTH-1:0] max_velocity_i,
  input  logic [RandWidth-1:0]          rand_personal_i,
  input  logic [RandWidth-1:0]          rand_social_i,
  input  logic signed [VALUE_WIDTH-1:0] global_best_element_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [IndexWidth-1:0]         result_index_o,
  output logic signed [VALUE_WIDTH-1:0] new_position_o,
  output logic signed [VALUE_WIDTH-1:0] new_velocity_o,
  output logic                          personal_improved_o,
  output logic                          global_improved_o,
  output logic [GenWidth-1:0]           generation_o,
  output logic                          finished_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int AW   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int ActW = ($clog2(MAX_DIMENSIONS + 1) > DimCntWidth) ?
                        $clog2(MAX_DIMENSIONS + 1) : DimCntWidth;
  localparam logic [ActW-1:0] MaxDims = ActW'(MAX_DIMENSIONS);
  // Product and term widths of the velocity datapath.
  localparam int KPW = CoefWidth + RandWidth + 1;  // c * r
  localparam int KW  = KPW - FracBits;             // k
  localparam int DW  = W + 1;                      // target - x
  localparam int APW = KW + DW;                    // k * d
  localparam int AT  = APW - FracBits;
  localparam int WPW = CoefWidth + W;              // w * v
  localparam int WT  = WPW - FracBits;
  localparam int SW  = AT + 2;                     // sum of three terms

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL2, ST_VEL, ST_POS, ST_COPY_RD, ST_COPY_WR, ST_EMIT
  } state_e;

  // Memory rows: {position, velocity, personal best} and the four limits.
  typedef struct packed {
    logic signed [W-1:0] pos;
    logic signed [W-1:0] vel;
    logic signed [W-1:0] pbest;
  } state_row_t;

  typedef struct packed {
    logic signed [W-1:0] pmin;
    logic signed [W-1:0] pmax;
    logic signed [W-1:0] vmin;
    logic signed [W-1:0] vmax;
  } limit_row_t;

  state_row_t state_mem [MAX_DIMENSIONS];
  limit_row_t limit_mem [MAX_DIMENSIONS];
  state_row_t st_rd_q;
  limit_row_t lim_rd_q;

  // Configuration.
  logic signed [CoefWidth-1:0] inertia_q, personal_q, social_q;
  logic [DimCntWidth-1:0]      dim_count_q;
  logic [GenWidth-1:0]         gen_limit_q;

  state_e                   state_q;
  logic [ActW-1:0]          cnt_q;
  logic [AW-1:0]            idx_q;
  logic [IndexWidth-1:0]    res_idx_q;
  logic signed [W-1:0]      gbest_q;
  logic [RandWidth-1:0]     r1_q, r2_q;
  logic signed [W-1:0]      pbest_fit_q;
  logic [GenWidth-1:0]      gen_q;
  logic signed [W-1:0]      np_q, nv_q;
  logic                     pimp_q, gimp_q;

  logic signed [KPW-1:0]    kp1_q, kp2_q;
  logic signed [WPW-1:0]    wp_q;
  logic signed [DW-1:0]     d1_q, d2_q;
  logic signed [APW-1:0]    ap1_q, ap2_q;
  logic signed [WT-1:0]     wt_q;

  logic                     out_valid_q;
  logic [IndexWidth-1:0]    out_idx_q;
  logic signed [W-1:0]      out_pos_q, out_vel_q;
  logic                     out_pimp_q, out_gimp_q, out_fin_q;
  logic [GenWidth-1:0]      out_gen_q;

  // Combinational helpers.
  logic                     in_accept;
  logic [ActW-1:0]          dim_ext;
  logic [ActW-1:0]          active_dims;
  logic                     in_use;
  logic [AW-1:0]            in_addr;
  logic [RandWidth-1:0]     r1_sat, r2_sat;
  logic signed [SW-1:0]     vel_sum;
  logic signed [W-1:0]      vel_clamped;
  logic signed [DW-1:0]     pos_sum;
  logic signed [W-1:0]      pos_clamped;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign dim_ext     = ActW'(dim_count_q);
  assign active_dims = (dim_ext > MaxDims) ? MaxDims : dim_ext;
  assign in_use      = ActW'(index_i) < active_dims;
  assign in_addr     = AW'(index_i);

  assign r1_sat = (r1_q > RandOne) ? RandOne : r1_q;
  assign r2_sat = (r2_q > RandOne) ? RandOne : r2_q;

  // The three terms are each floor-shifted before they are summed.
  assign vel_sum = SW'(wt_q) + SW'($signed(ap1_q[APW-1:FracBits])) +
                   SW'($signed(ap2_q[APW-1:FracBits]));
  assign pos_sum = DW'(st_rd_q.pos) + DW'(nv_q);

  pso_limit_clamp #(.W(W), .IW(SW)) u_vel_clamp (
    .value_i (vel_sum),
    .lo_i    (lim_rd_q.vmin),
    .hi_i    (lim_rd_q.vmax),
    .value_o (vel_clamped)
  );

  pso_limit_clamp #(.W(W), .IW(DW)) u_pos_clamp (
    .value_i (pos_sum),
    .lo_i    (lim_rd_q.pmin),
    .hi_i    (lim_rd_q.pmax),
    .value_o (pos_clamped)
  );

  // Reads happen only when an item is accepted and during the copy sweep, so
  // the read register keeps the row for the whole update.
  assign rd_en   = in_accept || (state_q == ST_COPY_RD);
  assign rd_addr = (state_q == ST_COPY_RD) ? cnt_q[AW-1:0] : in_addr;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      st_rd_q  <= state_mem[rd_addr];
      lim_rd_q <= limit_mem[rd_addr];
    end
  end

  // Single write port per memory. A load writes at acceptance, an update at
  // the end of its pass, the copy sweep one row in each of its write states.
  always_ff @(posedge clk_i) begin
    if (in_accept && action_e'(action_i) == ACT_LOAD && in_use) begin
      state_mem[in_addr] <= '{pos: primary_value_i, vel: secondary_value_i,
                              pbest: primary_value_i};
      limit_mem[in_addr] <= '{pmin: min_position_i, pmax: max_position_i,
                              vmin: min_velocity_i, vmax: max_velocity_i};
    end else if (state_q == ST_POS) begin
      state_mem[idx_q] <= '{pos: pos_clamped, vel: nv_q, pbest: st_rd_q.pbest};
    end else if (state_q == ST_COPY_WR) begin
      state_mem[cnt_q[AW-1:0]] <= '{pos: st_rd_q.pos, vel: st_rd_q.vel,
                                    pbest: st_rd_q.pos};
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      idx_q     <= in_addr;
      // Reports and fitness writes carry index zero.
      res_idx_q <= (action_e'(action_i) == ACT_REPORT ||
                    action_e'(action_i) == ACT_SETFIT) ? '0 : index_i;
      gbest_q   <= global_best_element_i;
      r1_q      <= rand_personal_i;
      r2_q      <= rand_social_i;
    end
    if (state_q == ST_READ) begin
      kp1_q <= KPW'(personal_q * $signed({1'b0, r1_sat}));
      kp2_q <= KPW'(social_q * $signed({1'b0, r2_sat}));
      wp_q  <= WPW'(inertia_q * st_rd_q.vel);
      d1_q  <= DW'(st_rd_q.pbest) - DW'(st_rd_q.pos);
      d2_q  <= DW'(gbest_q) - DW'(st_rd_q.pos);
    end
    if (state_q == ST_MUL2) begin
      ap1_q <= APW'($signed(kp1_q[KPW-1:FracBits]) * d1_q);
      ap2_q <= APW'($signed(kp2_q[KPW-1:FracBits]) * d2_q);
      wt_q  <= wp_q[WPW-1:FracBits];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inertia_q   <= ResetInertia;
      personal_q  <= ResetAccel;
      social_q    <= ResetAccel;
      dim_count_q <= '0;
      gen_limit_q <= '0;
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pbest_fit_q <= '0;
      gen_q       <= '0;
      np_q        <= '0;
      nv_q        <= '0;
      pimp_q      <= 1'b0;
      gimp_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_pos_q   <= '0;
      out_vel_q   <= '0;
      out_pimp_q  <= 1'b0;
      out_gimp_q  <= 1'b0;
      out_gen_q   <= '0;
      out_fin_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_INERTIA:  inertia_q   <= cfg_data_i;
          CFG_PERSONAL: personal_q  <= cfg_data_i;
          CFG_SOCIAL:   social_q    <= cfg_data_i;
          CFG_DIMCOUNT: dim_count_q <= cfg_data_i[DimCntWidth-1:0];
          CFG_GENLIMIT: gen_limit_q <= cfg_data_i[GenWidth-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            np_q   <= '0;
            nv_q   <= '0;
            pimp_q <= 1'b0;
            gimp_q <= 1'b0;
            state_q <= ST_EMIT;
            case (action_e'(action_i))
              ACT_LOAD: begin
              end
              ACT_UPDATE: begin
                if (in_use) begin
                  state_q <= ST_READ;
                end
              end
              ACT_REPORT: begin
                if (gen_q != '1) begin
                  gen_q <= gen_q + 1'b1;
                end
                gimp_q <= primary_value_i > secondary_value_i;
                if (primary_value_i > pbest_fit_q) begin
                  pbest_fit_q <= primary_value_i;
                  pimp_q      <= 1'b1;
                  cnt_q       <= '0;
                  if (active_dims != '0) begin
                    state_q <= ST_COPY_RD;
                  end
                end
              end
              ACT_SETFIT: begin
                pbest_fit_q <= primary_value_i;
              end
              default: ;
            endcase
          end
        end
        ST_READ:    state_q <= ST_MUL2;
        ST_MUL2:    state_q <= ST_VEL;
        ST_VEL: begin
          nv_q    <= vel_clamped;
          state_q <= ST_POS;
        end
        ST_POS: begin
          np_q    <= pos_clamped;
          state_q <= ST_EMIT;
        end
        ST_COPY_RD: state_q <= ST_COPY_WR;
        ST_COPY_WR: begin
          cnt_q <= cnt_q + 1'b1;
          state_q <= (cnt_q + 1'b1 == active_dims) ? ST_EMIT : ST_COPY_RD;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_pos_q   <= np_q;
            out_vel_q   <= nv_q;
            out_pimp_q  <= pimp_q;
            out_gimp_q  <= gimp_q;
            out_gen_q   <= gen_q;
            out_fin_q   <= (gen_limit_q != '0) && (gen_q > gen_limit_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_index_o      = out_idx_q;
  assign new_position_o      = out_pos_q;
  assign new_velocity_o      = out_vel_q;
  assign personal_improved_o = out_pimp_q;
  assign global_improved_o   = out_gimp_q;
  assign generation_o        = out_gen_q;
  assign finished_o          = out_fin_q;

endmodule
